// ===== src/bct_pkg.sv =====
// shared types and constants of the bound change table
package bct_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int COL_W       = 30;
  localparam int VAL_W       = 64;
  localparam int COUNT_OUT_W = 5;

  localparam logic [VAL_W-1:0] NEG_INF = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] POS_INF = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_APPLY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APP_HI,
    S_APP_LO,
    S_OUT
  } state_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic             active;
    logic [COL_W-1:0] col;
    logic [1:0]       force_req;
    logic [VAL_W-1:0] lower;
    logic [VAL_W-1:0] upper;
    logic [VAL_W-1:0] run_lo;
    logic [VAL_W-1:0] run_hi;
    logic             seen_lo;
    logic             seen_hi;
  } sweep_t;

  // entry write bus from the controller
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             upper_kind;
    logic             odd_mark;
    logic [VAL_W-1:0] value;
  } entry_wr_t;

endpackage

// ===== src/bct_cell.sv =====
// one table entry plus one stage of the scan chain
module bct_cell
  import bct_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      occupied,
  input  logic      wr_en,
  input  entry_wr_t wr,
  input  sweep_t    sweep_in,
  output sweep_t    sweep_out
);

  logic [COL_W-1:0] e_col;
  logic             e_up;
  logic             e_odd;
  logic [VAL_W-1:0] e_val;
  logic             e_odd_next;
  logic [VAL_W-1:0] e_val_next;
  sweep_t           sweep_next;
  logic             hit;

  always_comb begin
    sweep_next = sweep_in;
    e_val_next = e_val;
    e_odd_next = e_odd;
    hit        = sweep_in.active && occupied && (e_col == sweep_in.col);
    if (hit) begin
      if (!e_up) begin
        sweep_next.seen_lo = 1'b1;
        if ($signed(e_val) > $signed(sweep_in.run_lo)) sweep_next.run_lo = e_val;
        if (!sweep_in.force_req[0]) begin
          sweep_next.lower = e_val;
        end else begin
          e_val_next = sweep_in.lower;
          e_odd_next = 1'b1;
        end
      end else begin
        sweep_next.seen_hi = 1'b1;
        if ($signed(e_val) < $signed(sweep_in.run_hi)) sweep_next.run_hi = e_val;
        if (!sweep_in.force_req[1]) begin
          sweep_next.upper = e_val;
        end else begin
          e_val_next = sweep_in.upper;
          e_odd_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      e_col <= wr.col;
      e_up  <= wr.upper_kind;
      e_odd <= wr.odd_mark;
      e_val <= wr.value;
    end else begin
      e_odd <= e_odd_next;
      e_val <= e_val_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_out.active <= 1'b0;
    end else begin
      sweep_out <= sweep_next;
    end
  end

endmodule

// ===== src/bound_change_table_top.sv =====
// bound change table: controller, entry count and the chain of entry cells
//
// channel  | dir | payload (low bit first)
// s_axis   | in  | tdata: column, may_go_odd, entry_bound, lower_in, upper_in, force_req
//          |     | tuser: operation, is_upper
// m_axis   | out | tdata: lower_out, upper_out, infeasible, overflow, count_now
//
// clear, load and the unused code pass from the controller straight to its output step
// and then to the output register; on an apply the token walks the chain one cell a
// cycle, then come the two append steps, then output
// one request is worked on at a time; a new request is taken while the previous
// result still waits in the output register
// a stalled output holds the controller in its output step until the slot frees
// reset clears the entry count, the state and the valid flags; entries are not cleared
module bound_change_table_top
  import bct_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // column[29:0], may_go_odd[30], entry_bound[94:31], lower_in[158:95],
  // upper_in[222:159], force_req[224:223], zero pad[231:225]
  input  logic [231:0] s_axis_tdata,
  // operation[1:0], is_upper[2]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // lower_out[63:0], upper_out[127:64], infeasible[128], overflow[129],
  // count_now[134:130], zero pad[135]
  output logic [135:0] m_axis_tdata
);

  // unpack the request
  logic [COL_W-1:0] in_col;
  logic             in_odd;
  logic [VAL_W-1:0] in_bound;
  logic [VAL_W-1:0] in_lower;
  logic [VAL_W-1:0] in_upper;
  logic [1:0]       in_force;
  op_t              in_op;
  logic             in_is_upper;

  assign in_col      = s_axis_tdata[29:0];
  assign in_odd      = s_axis_tdata[30];
  assign in_bound    = s_axis_tdata[94:31];
  assign in_lower    = s_axis_tdata[158:95];
  assign in_upper    = s_axis_tdata[222:159];
  assign in_force    = s_axis_tdata[224:223];
  assign in_op       = op_t'(s_axis_tuser[1:0]);
  assign in_is_upper = s_axis_tuser[2];

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic             full;
  logic             accept;
  logic             wr_req;
  entry_wr_t        wr;
  logic             ovf_set;
  logic             inject;
  logic             out_load;

  // request held during the scan and appends
  logic [COL_W-1:0] it_col;
  logic [1:0]       it_force;

  // result under construction
  logic [VAL_W-1:0] res_lower;
  logic [VAL_W-1:0] res_upper;
  logic [VAL_W-1:0] run_lo_q;
  logic [VAL_W-1:0] run_hi_q;
  logic             seen_lo_q;
  logic             seen_hi_q;
  logic             res_inf;
  logic             res_ovf;

  sweep_t               sweep_chain [0:MAX_ENTRIES];
  sweep_t               sweep_last;
  logic [CNT_W+4:0]     count_ext;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign full          = (count == CNT_W'(MAX_ENTRIES));
  assign sweep_last    = sweep_chain[MAX_ENTRIES];

  // token entering the first cell on an apply
  always_comb begin
    sweep_chain[0].active    = inject;
    sweep_chain[0].col       = in_col;
    sweep_chain[0].force_req = in_force;
    sweep_chain[0].lower     = in_lower;
    sweep_chain[0].upper     = in_upper;
    sweep_chain[0].run_lo    = NEG_INF;
    sweep_chain[0].run_hi    = POS_INF;
    sweep_chain[0].seen_lo   = 1'b0;
    sweep_chain[0].seen_hi   = 1'b0;
  end

  // row of entry cells; the write goes to the slot at the current count
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    bct_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .occupied  (count > CNT_W'(i)),
      .wr_en     (wr_req && (count == CNT_W'(i))),
      .wr        (wr),
      .sweep_in  (sweep_chain[i]),
      .sweep_out (sweep_chain[i+1])
    );
  end

  // next state, table writes and count
  always_comb begin
    state_next = state;
    count_next = count;
    wr_req     = 1'b0;
    wr         = '{col: in_col, upper_kind: in_is_upper, odd_mark: in_odd,
                   value: in_bound};
    ovf_set    = 1'b0;
    inject     = 1'b0;
    out_load   = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_CLEAR: begin
              count_next = '0;
              state_next = S_OUT;
            end
            OP_LOAD: begin
              if (!full) begin
                wr_req     = 1'b1;
                count_next = count + CNT_W'(1);
              end
              state_next = S_OUT;
            end
            OP_APPLY: begin
              inject     = 1'b1;
              state_next = S_SCAN;
            end
            default: begin
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (sweep_last.active) state_next = S_APP_HI;
      end
      S_APP_HI: begin
        // upper append comes first
        if (it_force[1] && !seen_hi_q) begin
          if (full) begin
            ovf_set = 1'b1;
          end else begin
            wr_req     = 1'b1;
            wr         = '{col: it_col, upper_kind: 1'b1, odd_mark: 1'b0, value: run_hi_q};
            count_next = count + CNT_W'(1);
          end
        end
        state_next = S_APP_LO;
      end
      S_APP_LO: begin
        if (it_force[0] && !seen_lo_q) begin
          if (full) begin
            ovf_set = 1'b1;
          end else begin
            wr_req     = 1'b1;
            wr         = '{col: it_col, upper_kind: 1'b0, odd_mark: 1'b0, value: run_lo_q};
            count_next = count + CNT_W'(1);
          end
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // result datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      it_col    <= in_col;
      it_force  <= in_force;
      res_lower <= '0;
      res_upper <= '0;
      res_inf   <= 1'b0;
      res_ovf   <= (in_op == OP_LOAD) && full;
    end else if (state == S_SCAN && sweep_last.active) begin
      // fold the final bounds into the running extremes
      res_lower <= sweep_last.lower;
      res_upper <= sweep_last.upper;
      run_lo_q  <= ($signed(sweep_last.lower) > $signed(sweep_last.run_lo)) ?
                   sweep_last.lower : sweep_last.run_lo;
      run_hi_q  <= ($signed(sweep_last.upper) < $signed(sweep_last.run_hi)) ?
                   sweep_last.upper : sweep_last.run_hi;
      seen_lo_q <= sweep_last.seen_lo;
      seen_hi_q <= sweep_last.seen_hi;
    end else if (state == S_APP_HI) begin
      res_inf <= $signed(run_hi_q) < $signed(run_lo_q);
      if (ovf_set) res_ovf <= 1'b1;
    end else if (ovf_set) begin
      res_ovf <= 1'b1;
    end
  end

  // output register
  assign count_ext = (CNT_W+5)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {1'b0, count_ext[COUNT_OUT_W-1:0], res_ovf, res_inf,
                       res_upper, res_lower};
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above table size");

  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    sweep_last.active |-> state == S_SCAN)
    else $error("scan token left the chain outside a scan");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && sweep_last.active) |=> state == S_APP_HI)
    else $error("scan did not move on to the append steps");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && res_ovf) |-> full)
    else $error("overflow reported with room left in the table");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !wr_req)
    else $error("table write during a scan");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the bound change table: predicting scoreboard and stream drivers
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bct_pkg::*;

  // stop points of the run
  localparam int ITEM_TARGET  = 1700;  // clear, load and apply requests sent in all, directed part included
  localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES = 40;    // longer than one apply

  // one request as the block sees it
  typedef struct {
    op_t              op;
    logic [COL_W-1:0] column;
    logic             is_upper;
    logic             may_go_odd;
    logic [VAL_W-1:0] entry_bound;
    logic [VAL_W-1:0] lower_in;
    logic [VAL_W-1:0] upper_in;
    logic [1:0]       force_req;
  } bound_req_t;

  // one result, fields in m_axis_tdata order from the top down
  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count_now;
    logic                   overflow;
    logic                   infeasible;
    logic [VAL_W-1:0]       upper_out;
    logic [VAL_W-1:0]       lower_out;
  } bound_res_t;

  // keeps its own copy of the change table and the results still due
  class bound_table_scoreboard;
    logic [COL_W-1:0]        ent_col[MAX_ENTRIES];
    logic                    ent_up[MAX_ENTRIES];
    logic                    ent_odd[MAX_ENTRIES];
    logic signed [VAL_W-1:0] ent_val[MAX_ENTRIES];
    int                      n_entries;
    bound_res_t              bounds_due_q[$];
    int                      mismatches;
    int                      requests_seen;
    int                      applies_checked;
    int                      infeasible_hits;
    int                      overflow_hits;

    function new();
      n_entries = 0;
      mismatches = 0;
      requests_seen = 0;
      applies_checked = 0;
      infeasible_hits = 0;
      overflow_hits = 0;
    endfunction

    function bit push_entry(logic [COL_W-1:0] c, logic up, logic odd,
                            logic signed [VAL_W-1:0] v);
      if (n_entries >= MAX_ENTRIES) return 1'b0;
      ent_col[n_entries] = c;
      ent_up[n_entries]  = up;
      ent_odd[n_entries] = odd;
      ent_val[n_entries] = v;
      n_entries++;
      return 1'b1;
    endfunction

    // works out the result of one request and updates the table copy
    function bound_res_t apply_table_item(bound_req_t r);
      bound_res_t              res;
      logic signed [VAL_W-1:0] lo, hi, run_lo, run_hi;
      bit                      seen_lo, seen_hi;
      res = '0;
      case (r.op)
        OP_CLEAR: n_entries = 0;
        OP_LOAD: begin
          if (!push_entry(r.column, r.is_upper, r.may_go_odd, r.entry_bound))
            res.overflow = 1'b1;
        end
        OP_APPLY: begin
          lo = r.lower_in;
          hi = r.upper_in;
          run_lo = NEG_INF;
          run_hi = POS_INF;
          seen_lo = 1'b0;
          seen_hi = 1'b0;
          for (int i = 0; i < n_entries; i++) begin
            if (ent_col[i] == r.column) begin
              if (!ent_up[i]) begin
                seen_lo = 1'b1;
                if (ent_val[i] > run_lo) run_lo = ent_val[i];
                if (r.force_req[0]) begin
                  ent_val[i] = lo;
                  ent_odd[i] = 1'b1;
                end else begin
                  lo = ent_val[i];
                end
              end else begin
                seen_hi = 1'b1;
                if (ent_val[i] < run_hi) run_hi = ent_val[i];
                if (r.force_req[1]) begin
                  ent_val[i] = hi;
                  ent_odd[i] = 1'b1;
                end else begin
                  hi = ent_val[i];
                end
              end
            end
          end
          if (lo > run_lo) run_lo = lo;
          if (hi < run_hi) run_hi = hi;
          // missing forced kinds go to the end, upper first
          if (r.force_req[1] && !seen_hi && !push_entry(r.column, 1'b1, 1'b0, run_hi))
            res.overflow = 1'b1;
          if (r.force_req[0] && !seen_lo && !push_entry(r.column, 1'b0, 1'b0, run_lo))
            res.overflow = 1'b1;
          res.lower_out  = lo;
          res.upper_out  = hi;
          res.infeasible = (run_hi < run_lo);
        end
        default: ;
      endcase
      res.count_now = n_entries[COUNT_OUT_W-1:0];
      return res;
    endfunction

    function void note_request(bound_req_t r);
      requests_seen++;
      bounds_due_q.push_back(apply_table_item(r));
    endfunction

    function void check_result(logic [135:0] raw);
      bound_res_t got, want;
      got = raw[134:0];
      if (bounds_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t result with none due: lo %h hi %h inf %b ovf %b cnt %0d", $realtime,
                   got.lower_out, got.upper_out, got.infeasible, got.overflow, got.count_now);
        return;
      end
      want = bounds_due_q.pop_front();
      if (want.infeasible) infeasible_hits++;
      if (want.overflow) overflow_hits++;
      if (want.lower_out != '0 || want.upper_out != '0) applies_checked++;
      if (got.lower_out !== want.lower_out || got.upper_out !== want.upper_out ||
          got.infeasible !== want.infeasible || got.overflow !== want.overflow ||
          got.count_now !== want.count_now || raw[135] !== 1'b0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%t result differs (want / got):", $realtime);
          $display("  lower_out %h / %h  upper_out %h / %h", want.lower_out, got.lower_out,
                   want.upper_out, got.upper_out);
          $display("  infeasible %b / %b  overflow %b / %b  count_now %0d / %0d pad %b",
                   want.infeasible, got.infeasible, want.overflow, got.overflow,
                   want.count_now, got.count_now, raw[135]);
        end
      end
    endfunction

    function int outstanding();
      return bounds_due_q.size();
    endfunction
  endclass

  logic         clk;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // column, may_go_odd, entry_bound, lower_in, upper_in, force_req, zero pad
  logic [231:0] s_axis_tdata = '0;
  // operation, is_upper
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // lower_out, upper_out, infeasible, overflow, count_now, zero pad
  logic [135:0] m_axis_tdata;

  bound_table_scoreboard sb = new();

  // steady flags switch off idling on one side for a stretch of requests
  bit steady_src = 1'b0;
  bit steady_snk = 1'b0;
  int work_sent = 0;
  int quiet_cycles = 0;
  logic [COL_W-1:0] col_pool[4];

  bound_change_table_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // request builders
  // --------------------------------------------------------------------------

  // every field random, unused fields of a request keep their random bits
  function automatic bound_req_t random_req();
    bound_req_t r;
    r.op          = op_t'($urandom_range(0, 3));
    r.column      = COL_W'($urandom());
    r.is_upper    = 1'($urandom_range(0, 1));
    r.may_go_odd  = 1'($urandom_range(0, 1));
    r.entry_bound = {$urandom(), $urandom()};
    r.lower_in    = {$urandom(), $urandom()};
    r.upper_in    = {$urandom(), $urandom()};
    r.force_req   = 2'($urandom_range(0, 3));
    return r;
  endfunction

  function automatic bound_req_t op_req(op_t op);
    bound_req_t r;
    r = random_req();
    r.op = op;
    return r;
  endfunction

  function automatic bound_req_t load_req(logic [COL_W-1:0] c, logic up, logic odd,
                                          logic [VAL_W-1:0] v);
    bound_req_t r;
    r = op_req(OP_LOAD);
    r.column = c;
    r.is_upper = up;
    r.may_go_odd = odd;
    r.entry_bound = v;
    return r;
  endfunction

  function automatic bound_req_t apply_req(logic [COL_W-1:0] c, logic [VAL_W-1:0] lo,
                                           logic [VAL_W-1:0] hi, logic [1:0] f);
    bound_req_t r;
    r = op_req(OP_APPLY);
    r.column = c;
    r.lower_in = lo;
    r.upper_in = hi;
    r.force_req = f;
    return r;
  endfunction

  // infinities, their neighbours, zero, small values that collide often, any code
  function automatic logic [VAL_W-1:0] pick_bound();
    logic signed [VAL_W-1:0] v;
    int k;
    case ($urandom_range(0, 9))
      0: v = NEG_INF;
      1: v = POS_INF;
      2: v = NEG_INF + 1;
      3: v = POS_INF - 1;
      4: v = '0;
      5, 6, 7: begin
        k = $urandom_range(0, 64);
        k -= 32;
        v = k;
        v = v <<< 30;  // quarter steps in Q32.32
      end
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  // a handful of columns per sequence so that applies find matches
  function automatic void refresh_pool();
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(0, 3))
        0: col_pool[i] = '0;
        1: col_pool[i] = '1;
        2: col_pool[i] = COL_W'($urandom_range(0, 7));
        default: col_pool[i] = COL_W'($urandom());
      endcase
    end
  endfunction

  function automatic logic [COL_W-1:0] pick_column();
    if ($urandom_range(0, 19) < 17) return col_pool[$urandom_range(0, 3)];
    return COL_W'($urandom());
  endfunction

  // --------------------------------------------------------------------------
  // request driver: valid stays high between back-to-back requests
  // --------------------------------------------------------------------------
  task automatic send_request(bound_req_t r);
    int gap;
    gap = steady_src ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, r.force_req, r.upper_in, r.lower_in, r.entry_bound,
                      r.may_go_odd, r.column};
    s_axis_tuser  <= {r.is_upper, r.op};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(r);
    if (r.op != OP_NONE) work_sent++;
  endtask

  // --------------------------------------------------------------------------
  // directed part: empty table, infinities, forced and unforced matches,
  // appends, the last free slot, full table, unused code
  // --------------------------------------------------------------------------
  task automatic run_directed();
    send_request(apply_req('0, NEG_INF, POS_INF, 2'b00));      // nothing stored yet
    send_request(op_req(OP_NONE));
    send_request(load_req('1, 1'b0, 1'b1, NEG_INF));
    send_request(load_req('0, 1'b1, 1'b0, POS_INF));
    send_request(load_req('1, 1'b1, 1'b1, 64'sd3 <<< 32));
    // unforced match overwrites both inputs with the stored bounds, so upper below lower is not infeasible
    send_request(apply_req('1, POS_INF, NEG_INF, 2'b00));
    // forced match writes the inputs back into the entries
    send_request(apply_req('1, 64'sd5 <<< 32, 64'sd2 <<< 32, 2'b11));
    // no match for either kind: upper then lower appended
    send_request(apply_req(COL_W'(5), -(64'sd1 <<< 32), 64'sd1 <<< 32, 2'b11));
    send_request(apply_req(COL_W'(5), NEG_INF, POS_INF, 2'b01));
    repeat (10) send_request(load_req(COL_W'(7), 1'b0, 1'b0, pick_bound()));
    // one free slot left: upper append kept, lower append dropped
    send_request(apply_req(COL_W'(9), '0, '0, 2'b11));
    send_request(load_req(COL_W'(7), 1'b1, 1'b1, POS_INF));   // full on load
    send_request(apply_req(COL_W'(11), POS_INF, NEG_INF, 2'b10));
    send_request(op_req(OP_NONE));
    send_request(op_req(OP_CLEAR));
    send_request(apply_req(COL_W'(7), NEG_INF, NEG_INF, 2'b00));
  endtask

  // --------------------------------------------------------------------------
  // random part: mostly fill-then-apply sequences over a small column pool,
  // with skipped clears, overfilled tables and stray requests mixed in
  // --------------------------------------------------------------------------
  task automatic run_random();
    int loads;
    int applies;
    while (work_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 7) == 0) steady_src = !steady_src;
      if ($urandom_range(0, 7) == 0) steady_snk = !steady_snk;
      refresh_pool();
      if ($urandom_range(0, 3) != 0) send_request(op_req(OP_CLEAR));
      loads = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 19) : $urandom_range(0, 8);
      repeat (loads)
        send_request(load_req(pick_column(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), pick_bound()));
      applies = $urandom_range(1, 8);
      repeat (applies) begin
        if ($urandom_range(0, 15) == 0) send_request(random_req());
        send_request(apply_req(pick_column(), pick_bound(), pick_bound(),
                               2'($urandom_range(0, 3))));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // result side: random stalls, every accepted result goes to the scoreboard
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady_snk ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  // watchdog: any handshake restarts the count
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: %0d cycles without a handshake, %0d results still due",
               quiet_cycles, sb.outstanding());
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    s_axis_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests: %0d applies with a nonzero bound, %0d infeasible, %0d dropped",
             sb.requests_seen, sb.applies_checked, sb.infeasible_hits, sb.overflow_hits);
    $display("writes on a full table; idle and stall gaps of 0 to 12 cycles on both sides");
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/bct_pkg.sv
src/bct_cell.sv
src/bound_change_table_top.sv
verif/tb_top.sv
